/* sv/ihf_pkg.sv */
package ihf_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned FRAC_W      = 24;
    localparam int unsigned IBM_BIAS    = 64;
    localparam int unsigned IEEE_BIAS   = 127;
    localparam int unsigned IEEE_EMAX   = 255;
    localparam int unsigned SUB_SHIFT   = 149;

    typedef logic [WORD_W-1:0] t_word;

endpackage

/* sv/ihf_convert.sv */
module ihf_convert (
    input  ihf_pkg::t_word i_word,
    output ihf_pkg::t_word o_word
);
    import ihf_pkg::*;

    logic              sgn;
    logic [6:0]        xexp;
    logic [23:0]       frac;
    logic [4:0]        p;
    logic signed [10:0] biased;
    logic signed [10:0] e2;
    logic signed [10:0] s;
    logic [23:0]       m;
    logic [23:0]       q;
    logic [23:0]       r;
    logic [23:0]       half;
    logic [23:0]       rmask;
    logic [4:0]        sh;

    always_comb begin
        sgn  = i_word[31];
        xexp = i_word[30:24];
        frac = i_word[23:0];
        p = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (frac[i]) p = 5'(i);
        end
        e2 = 11'(signed'({4'd0, xexp}) * 4) - 11'(4 * IBM_BIAS + FRAC_W);
        biased = 11'(signed'({6'd0, p})) + e2 + 11'(IEEE_BIAS);
        s = -(e2 + 11'(SUB_SHIFT));
        m = frac << (5'd23 - p);
        sh = s[4:0];
        rmask = (24'd1 << sh) - 24'd1;
        q = frac >> sh;
        r = frac & rmask;
        half = (sh == 5'd0) ? 24'd0 : (24'd1 << (sh - 5'd1));
        o_word = {sgn, 31'd0};
        if (frac == 24'd0) begin
            o_word = {sgn, 31'd0};
        end else if (biased >= signed'(11'(IEEE_EMAX))) begin
            o_word = {sgn, 8'hFF, 23'd0};
        end else if (biased >= 11'sd1) begin
            o_word = {sgn, biased[7:0], m[22:0]};
        end else if (s <= 11'sd0) begin
            // exact subnormal, shift left by -s (at most 21 bits)
            o_word = {sgn, 31'(frac << 5'(-s))};
        end else if (s >= 11'sd26) begin
            o_word = {sgn, 31'd0};
        end else begin
            if (r > half || (r == half && q[0])) q = q + 24'd1;
            o_word = {sgn, 7'd0, q};
        end
    end

endmodule

/* sv/ibm_hex_float_to_ieee_single_unit.sv */
// channel | valid    | stall    | payload
// input   | i_valid  | o_stall  | i_ibm_word
// output  | o_valid  | i_stall  | o_ieee_word
// One item per cycle while the output is not stalled; a result appears in the cycle after its item is accepted.
// The conversion is a single combinational pass into the output register.
// Reset clears the output valid only. An output stall holds the result;
// input stall follows it, so a new item enters whenever the result moves on.
module ibm_hex_float_to_ieee_single_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ihf_pkg::t_word i_ibm_word,
    output logic           o_valid,
    input  logic           i_stall,
    output ihf_pkg::t_word o_ieee_word
);
    import ihf_pkg::*;

    logic  r_valid;
    t_word r_word;
    t_word n_word;

    ihf_convert u_conv (
        .i_word (i_ibm_word),
        .o_word (n_word)
    );

    assign o_stall     = r_valid && i_stall;
    assign o_valid     = r_valid;
    assign o_ieee_word = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_word <= n_word;
        end
    end

`ifndef SYNTH
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ieee_word))
        else $error("held item changed");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("accepted item lost");
    a_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_ieee_word[30:23] == 8'hFF && o_ieee_word[22:0] != 23'd0))
        else $error("NaN produced");
`endif

endmodule
